>>> rtl/kf2_pkg.sv
// ----------------------------------------------------------------------------
// kf2_pkg
// Shared types, constants and a saturation helper for the two-state filter.
// ----------------------------------------------------------------------------
package kf2_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_POS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Q_CROSS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Q_VEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_U_POS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_U_VEL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR  = 3'd7;

    localparam logic signed [DW-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [DW-1:0] MINV = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] measured_pos;
        logic               restart;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] est_pos;
        logic signed [31:0] est_vel;
        logic signed [31:0] var_pos_out;
        logic signed [31:0] cov_out;
        logic signed [31:0] var_vel_out;
        logic               fault;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV0,
        ST_DIV1,
        ST_MUL,
        ST_DONE
    } t_state;

    // Saturate a 33-bit sum to 32 bits; bit 32 of result flags clamp
    function automatic logic [DW:0] sat33(input logic signed [DW:0] v);
        logic [DW:0] r;
        if (v > 33'sh0_7fffffff) r = {1'b1, MAXV};
        else if (v < -33'sh0_80000000) r = {1'b1, MINV};
        else r = {1'b0, v[DW-1:0]};
        return r;
    endfunction

endpackage

>>> rtl/kalman_filter_2state_top.sv
// ----------------------------------------------------------------------------
// kalman_filter_2state_top
// Two-state constant-velocity Kalman filter over signed Q16.16 values.
// ----------------------------------------------------------------------------
// After acceptance an item passes through a state that forms S, two serial
// divisions for the gain terms, 22 steps through a single shared multiply/add
// unit and a final state that loads the output register. When S is zero the
// divisions and the steps are skipped. Input ready is low from acceptance
// until the result is loaded; a result may then wait in the output register
// while the next item is accepted and computed, so a new item is accepted
// only after the last result is loaded. Registers may be written only while
// the block is idle.
module kalman_filter_2state_top
    import kf2_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]      i_cfg_data
);
    // micro-op step list
    localparam int NSTEP = 22;
    localparam int SW = $clog2(NSTEP);

    t_state r_state, n_state;
    logic [SW-1:0] r_step;

    // config
    logic [30:0] r_dt, r_rv, r_qp, r_qv, r_iv;
    logic signed [31:0] r_qc, r_up, r_uv;

    // filter state and scratch
    logic signed [DW-1:0] r_pos, r_vel, r_p00, r_p01, r_p11;
    logic signed [DW-1:0] r_z, r_s, r_y, r_k0, r_k1, r_n00, r_n01, r_n11, r_a, r_t;
    logic                 r_fault;
    t_out_item            r_out;
    logic                 r_ovld;

    // shared unit operands
    logic signed [DW-1:0] w_ma, w_mb, w_ad, w_res;
    logic                 w_mul, w_sub, w_sat;
    logic signed [2*DW-1:0] w_prod;
    logic signed [2*DW:0]   w_rnd;
    logic signed [DW:0]     w_sum;
    logic [DW:0]            w_satv;
    logic [2*DW:0]          w_mag;
    logic signed [DW-1:0]   w_dt, w_rv;

    logic                 w_dstart, w_ddone, w_dsat, w_load, w_szero;
    logic signed [DW-1:0] w_dquo, w_dnum, w_dden;
    logic [DW:0]          w_ssum, w_cov, w_vv;

    assign w_dt = $signed({1'b0, r_dt});
    assign w_rv = $signed({1'b0, r_rv});

    // Form S and the last two covariance sums
    assign w_ssum  = sat33({r_p00[DW-1], r_p00} + {w_rv[DW-1], w_rv});
    assign w_szero = (w_ssum[DW-1:0] == '0);
    assign w_cov   = sat33({r_a[DW-1], r_a} + {r_qc[31], r_qc});
    assign w_vv    = sat33({r_n11[DW-1], r_n11} + {2'b0, r_qv});

    // First division takes P00 over the fresh S, the second P01 over the held S
    assign w_dnum = (r_state == ST_SUM) ? r_p00 : r_p01;
    assign w_dden = (r_state == ST_SUM) ? w_ssum[DW-1:0] : r_s;

    kf2_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quo   (w_dquo),
        .o_sat   (w_dsat)
    );

    // Select operands per step: mul computes round(a*b), else a +/- add
    always_comb begin
        w_ma = '0; w_mb = '0; w_ad = '0; w_mul = 1'b0; w_sub = 1'b0;
        case (r_step)
            5'd0:  begin w_ma = r_z;   w_ad = r_pos; w_sub = 1'b1; end // y
            5'd1:  begin w_mul = 1'b1; w_ma = r_k0; w_mb = r_y;  end
            5'd2:  begin w_ma = r_pos; w_ad = r_t; end
            5'd3:  begin w_mul = 1'b1; w_ma = r_k1; w_mb = r_y;  end
            5'd4:  begin w_ma = r_vel; w_ad = r_t; end
            5'd5:  begin w_mul = 1'b1; w_ma = r_k0; w_mb = r_p00; end
            5'd6:  begin w_ma = r_p00; w_ad = r_t; w_sub = 1'b1; end
            5'd7:  begin w_mul = 1'b1; w_ma = r_k0; w_mb = r_p01; end
            5'd8:  begin w_ma = r_p01; w_ad = r_t; w_sub = 1'b1; end
            5'd9:  begin w_mul = 1'b1; w_ma = r_k1; w_mb = r_p01; end
            5'd10: begin w_ma = r_p11; w_ad = r_t; w_sub = 1'b1; end
            5'd11: begin w_mul = 1'b1; w_ma = w_dt; w_mb = r_vel; end
            5'd12: begin w_ma = r_pos; w_ad = r_t; end
            5'd13: begin w_ma = r_pos; w_ad = r_up; end
            5'd14: begin w_ma = r_vel; w_ad = r_uv; end
            5'd15: begin w_mul = 1'b1; w_ma = w_dt; w_mb = r_n11; end
            5'd16: begin w_ma = r_n01; w_ad = r_t; end
            5'd17: begin w_mul = 1'b1; w_ma = w_dt; w_mb = r_n01; end
            5'd18: begin w_ma = r_n00; w_ad = r_t; end
            5'd19: begin w_mul = 1'b1; w_ma = w_dt; w_mb = r_a; end
            5'd20: begin w_ma = r_n00; w_ad = r_t; end
            5'd21: begin w_ma = r_n00; w_ad = $signed({1'b0, r_qp}); end
            default: begin w_ma = '0; end
        endcase
    end

    // Shared unit: 32x32 multiply with rounding, or saturating add
    always_comb begin
        w_prod = w_ma * w_mb;
        w_mag  = w_prod[2*DW-1] ? -{w_prod[2*DW-1], w_prod} : {1'b0, w_prod};
        w_mag  = w_mag + (2*DW+1)'(1 << (FB-1));
        w_rnd  = $signed(w_mag >> FB);
        w_sum  = w_sub ? ({w_ma[DW-1], w_ma} - {w_ad[DW-1], w_ad})
                       : ({w_ma[DW-1], w_ma} + {w_ad[DW-1], w_ad});
        w_satv = sat33(w_sum);
        w_res  = w_satv[DW-1:0];
        w_sat  = w_satv[DW];
        if (w_mul) begin
            if (w_prod[2*DW-1]) begin
                if (w_rnd > 65'sh0_80000000) begin
                    w_res = MINV; w_sat = 1'b1;
                end else begin
                    w_res = -w_rnd[DW-1:0]; w_sat = 1'b0;
                end
            end else begin
                if (w_rnd > 65'sh0_7fffffff) begin
                    w_res = MAXV; w_sat = 1'b1;
                end else begin
                    w_res = w_rnd[DW-1:0]; w_sat = 1'b0;
                end
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid && o_in_ready) n_state = ST_SUM;
            ST_SUM:  n_state = w_szero ? ST_DONE : ST_DIV0;
            ST_DIV0: if (w_ddone) n_state = ST_DIV1;
            ST_DIV1: if (w_ddone) n_state = ST_MUL;
            ST_MUL:  if (r_step == SW'(NSTEP - 1)) n_state = ST_DONE;
            ST_DONE: if (!r_ovld || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
        w_dstart    = (r_state == ST_SUM && !w_szero) || (r_state == ST_DIV0 && w_ddone);
        w_load      = (r_state == ST_DONE) && (!r_ovld || i_out_ready);
    end

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= 31'd65536; r_rv <= 31'd65536; r_qp <= '0; r_qc <= '0;
            r_qv <= '0; r_up <= '0; r_uv <= '0; r_iv <= 31'd65536000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TIME_STEP: r_dt <= i_cfg_data[30:0];
                REG_MEAS_VAR:  r_rv <= i_cfg_data[30:0];
                REG_Q_POS:     r_qp <= i_cfg_data[30:0];
                REG_Q_CROSS:   r_qc <= i_cfg_data;
                REG_Q_VEL:     r_qv <= i_cfg_data[30:0];
                REG_U_POS:     r_up <= i_cfg_data;
                REG_U_VEL:     r_uv <= i_cfg_data;
                REG_INIT_VAR:  r_iv <= i_cfg_data[30:0];
                default:       r_dt <= r_dt;
            endcase
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovld   <= 1'b0;
            r_pos <= '0; r_vel <= '0; r_p01 <= '0;
            r_p00 <= 32'sd65536000; r_p11 <= 32'sd65536000;
        end else begin
            r_state <= n_state;
            // hold the result until taken; a new one replaces it on the same edge
            r_ovld  <= w_load || (r_ovld && !i_out_ready);
            if (w_load) r_out <= '{r_pos, r_vel, r_p00, r_p01, r_p11, r_fault};
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_z    <= i_in_item.measured_pos;
                        r_step <= '0;
                        if (i_in_item.restart) begin
                            r_pos <= '0; r_vel <= '0; r_p01 <= '0;
                            r_p00 <= $signed({1'b0, r_iv});
                            r_p11 <= $signed({1'b0, r_iv});
                        end
                    end
                end
                ST_SUM: begin
                    // a zero S skips the whole update
                    r_s     <= w_ssum[DW-1:0];
                    r_fault <= w_ssum[DW] || w_szero;
                end
                ST_DIV0: begin
                    if (w_ddone) begin
                        r_k0 <= w_dquo;
                        if (w_dsat) r_fault <= 1'b1;
                    end
                end
                ST_DIV1: begin
                    if (w_ddone) begin
                        r_k1 <= w_dquo;
                        if (w_dsat) r_fault <= 1'b1;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (w_sat || (r_step == 5'd21 && (w_cov[DW] || w_vv[DW])))
                        r_fault <= 1'b1;
                    case (r_step)
                        5'd0:  r_y <= w_res;
                        5'd2:  r_pos <= w_res;
                        5'd4:  r_vel <= w_res;
                        5'd6:  r_n00 <= w_res;
                        5'd8:  r_n01 <= w_res;
                        5'd10: r_n11 <= w_res;
                        5'd12: r_pos <= w_res;
                        5'd13: r_pos <= w_res;
                        5'd14: r_vel <= w_res;
                        5'd16: r_a   <= w_res;
                        5'd18: r_n00 <= w_res;
                        5'd20: r_n00 <= w_res;
                        5'd21: begin
                            r_p00 <= w_res;
                            r_p01 <= w_cov[DW-1:0];
                            r_p11 <= w_vv[DW-1:0];
                        end
                        default: r_t <= w_res;
                    endcase
                end
                default: r_step <= '0;
            endcase
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

    // Assertions
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cfg_ready) else $error("cfg ready while busy");
    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == ST_SUM) else $error("no start");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result dropped or changed while waiting");

endmodule

>>> rtl/kf2_div.sv
// ----------------------------------------------------------------------------
// kf2_div
// Restoring divider: rounded signed Q16.16 quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module kf2_div
    import kf2_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [DW-1:0]  i_num,
    input  logic signed [DW-1:0]  i_den,
    output logic                  o_done,
    output logic signed [DW-1:0]  o_quo,
    output logic                  o_sat
);
    // numerator magnitude shifted by FB: 48 bits, quotient up to 48 bits
    localparam int NW = DW + FB;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]   r_num;
    logic [DW:0]     r_rem;
    logic [DW-1:0]   r_den;
    logic [NW-1:0]   r_q;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_neg;
    logic            r_done;

    logic [DW+1:0]   w_trial;
    logic [DW+1:0]   w_sub;
    logic [NW:0]     w_qr;
    logic            w_rnd;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_sub   = w_trial - {2'b0, r_den};
    // round when rem >= den - rem
    assign w_rnd   = ({1'b0, r_rem} << 1) >= {2'b0, r_den};
    assign w_qr    = {1'b0, r_q} + {{NW{1'b0}}, w_rnd};

    // Count the quotient bits and flag the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {(i_num[DW-1] ? -i_num : i_num), {FB{1'b0}}};
            r_den <= i_den[DW-1] ? -i_den : i_den;
            r_neg <= i_num[DW-1] ^ i_den[DW-1];
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_num <= r_num << 1;
            if (!w_sub[DW+1]) begin
                r_rem <= w_sub[DW:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DW:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    // Apply sign and clamp to the data range
    always_comb begin
        o_sat = 1'b0;
        if (r_neg) begin
            if (w_qr > (NW+1)'(33'h0_80000000)) begin
                o_quo = MINV;
                o_sat = 1'b1;
            end else begin
                o_quo = -$signed(w_qr[DW-1:0]);
            end
        end else begin
            if (w_qr > (NW+1)'(32'h7fffffff)) begin
                o_quo = MAXV;
                o_sat = 1'b1;
            end else begin
                o_quo = $signed(w_qr[DW-1:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule
